[sv/des_pkg.sv]
// Package: DES permutation tables, S-boxes and round helper functions.
package des_pkg;

	localparam int NumRounds = 16;

	// Byte address of the key register on the configuration port
	localparam logic [2:0] ADDR_CIPHER_KEY = 3'd0;

	typedef logic [47:0] rkey_t;
	typedef logic [63:0] block_t;

	// Per-stage pipeline payload.
	typedef struct packed {
		logic        valid;
		logic        kind;
		logic        ok;
		logic [31:0] l;
		logic [31:0] r;
	} stage_t;

	localparam logic [6:0] TAB_IP [64] = '{
		58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,
		62,54,46,38,30,22,14,6,64,56,48,40,32,24,16,8,
		57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,
		61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};

	localparam logic [6:0] TAB_FP [64] = '{
		40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,
		38,6,46,14,54,22,62,30,37,5,45,13,53,21,61,29,
		36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,
		34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};

	localparam logic [5:0] TAB_E [48] = '{
		32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
		16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};

	localparam logic [5:0] TAB_P [32] = '{
		16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
		2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};

	localparam logic [6:0] TAB_PC1 [56] = '{
		57,49,41,33,25,17,9,1,58,50,42,34,26,18,
		10,2,59,51,43,35,27,19,11,3,60,52,44,36,
		63,55,47,39,31,23,15,7,62,54,46,38,30,22,
		14,6,61,53,45,37,29,21,13,5,28,20,12,4};

	localparam logic [5:0] TAB_PC2 [48] = '{
		14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
		41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};

	localparam logic [1:0] TAB_SHIFT [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

	localparam logic [3:0] TAB_S [8][64] = '{
		'{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
		 4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
		'{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
		 0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
		'{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
		 13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
		'{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
		 10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
		'{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
		 4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
		'{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
		 9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
		'{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
		 1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
		'{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
		 7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

	// Initial permutation.
	function automatic logic [63:0] perm_ip(input logic [63:0] x);
		logic [63:0] r;
		for (int i = 0; i < 64; i++) r[63-i] = x[64-TAB_IP[i]];
		return r;
	endfunction

	// Final permutation.
	function automatic logic [63:0] perm_fp(input logic [63:0] x);
		logic [63:0] r;
		for (int i = 0; i < 64; i++) r[63-i] = x[64-TAB_FP[i]];
		return r;
	endfunction

	// Pick the 56 key bits that matter, dropping parity, into the C and D halves.
	function automatic logic [55:0] perm_pc1(input logic [63:0] x);
		logic [55:0] r;
		for (int i = 0; i < 56; i++) r[55-i] = x[64-TAB_PC1[i]];
		return r;
	endfunction

	// Pick the 48 round-key bits from the rotated C and D halves.
	function automatic logic [47:0] perm_pc2(input logic [55:0] x);
		logic [47:0] r;
		for (int i = 0; i < 48; i++) r[47-i] = x[56-TAB_PC2[i]];
		return r;
	endfunction

	// Round function: expand the half block, mix in the key, S-boxes, permute.
	function automatic logic [31:0] round_f(input logic [31:0] r, input rkey_t k);
		logic [47:0] x;
		logic [31:0] s;
		logic [31:0] p;
		logic [5:0]  b;
		for (int i = 0; i < 48; i++) x[47-i] = r[32-TAB_E[i]];
		x = x ^ k;
		for (int i = 0; i < 8; i++) begin
			b = x[47-6*i -: 6];
			s[31-4*i -: 4] = TAB_S[i][{b[5], b[0], b[4:1]}];
		end
		for (int i = 0; i < 32; i++) p[31-i] = s[32-TAB_P[i]];
		return p;
	endfunction

endpackage

[sv/des_keysched.sv]
// Key schedule: derives and holds the 16 round keys and the key-loaded flag.
module des_keysched (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                key_wr,
	input  logic [63:0]         key,
	output des_pkg::rkey_t      rkeys [des_pkg::NumRounds],
	output logic                key_loaded
);

	logic [55:0] cd;
	logic [27:0] c_tmp [des_pkg::NumRounds+1];
	logic [27:0] d_tmp [des_pkg::NumRounds+1];
	des_pkg::rkey_t rkeys_q [des_pkg::NumRounds];
	logic key_loaded_q;

	// Rotate C and D through the shift schedule
	always_comb begin
		cd = des_pkg::perm_pc1(key);
		c_tmp[0] = cd[55:28];
		d_tmp[0] = cd[27:0];
		for (int i = 0; i < des_pkg::NumRounds; i++) begin
			if (des_pkg::TAB_SHIFT[i] == 2'd1) begin
				c_tmp[i+1] = {c_tmp[i][26:0], c_tmp[i][27]};
				d_tmp[i+1] = {d_tmp[i][26:0], d_tmp[i][27]};
			end else begin
				c_tmp[i+1] = {c_tmp[i][25:0], c_tmp[i][27:26]};
				d_tmp[i+1] = {d_tmp[i][25:0], d_tmp[i][27:26]};
			end
		end
	end

	// Load round keys on a key write
	always_ff @(posedge clk) begin
		if (key_wr) begin
			for (int i = 0; i < des_pkg::NumRounds; i++)
				rkeys_q[i] <= des_pkg::perm_pc2({c_tmp[i+1], d_tmp[i+1]});
		end
	end

	// Track whether a key was ever loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) key_loaded_q <= 1'b0;
		else if (key_wr) key_loaded_q <= 1'b1;
	end

	assign rkeys      = rkeys_q;
	assign key_loaded = key_loaded_q;

endmodule

[sv/des_round.sv]
// One pipelined Feistel round with its stage register.
module des_round (
	input  logic            clk,
	input  logic            arst_n,
	input  des_pkg::stage_t in_s,
	input  des_pkg::rkey_t  k_enc,
	input  des_pkg::rkey_t  k_dec,
	output des_pkg::stage_t out_s
);

	des_pkg::stage_t nxt;
	des_pkg::stage_t stg_s1;

	// Apply the round with the key chosen by the item's direction
	always_comb begin
		nxt   = in_s;
		nxt.l = in_s.r;
		nxt.r = in_s.l ^ des_pkg::round_f(in_s.r, in_s.kind ? k_dec : k_enc);
	end

	// Advance the stage; reset clears only the valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) stg_s1.valid <= 1'b0;
		else stg_s1 <= nxt;
	end

	assign out_s = stg_s1;

endmodule

[sv/des_block_cipher.sv]
// Top level: DES ECB cipher with APB key register and 18-stage pipeline.
//
// Usage: write the 64-bit key in one APB write to byte address 0; the round
// keys are derived at the accepting edge of that write and the key-loaded
// flag is set. Then pulse start with kind (0 encrypt, 1 decrypt) and
// block_in. busy is always low, so an item is accepted in every cycle that
// start is high.
// Each item passes an input register, sixteen round stages and an output
// register: done is high with the result on block_out/ok in the cycle after
// the output register takes it. Throughput is one item per cycle, set by the
// unrolled round stages, one Feistel round per stage.
// Reset clears all valid bits, the key register and the key-loaded flag;
// until a key is loaded every item returns block_out zero and ok low.
// The receiver cannot stall: each result is shown for one cycle only.
// Write the key only when no item is in flight.
module des_block_cipher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [63:0] block_in,
	output logic        done,
	output logic [63:0] block_out,
	output logic        ok
);

	localparam int NR = des_pkg::NumRounds;

	logic [63:0] key_q;
	logic        wr_en;
	logic        key_wr;
	logic        key_loaded;
	des_pkg::rkey_t  rkeys [NR];
	des_pkg::stage_t pipe [NR+1];
	des_pkg::stage_t in_s1;
	logic [63:0] t_ip;
	logic        done_q;
	logic [63:0] out_q;
	logic        ok_q;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign wr_en  = psel && penable && pwrite;
	assign key_wr = wr_en && (paddr == des_pkg::ADDR_CIPHER_KEY);

	// Hold the key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (key_wr) begin
			key_q <= pwdata;
		end
	end

	always_comb begin
		case (paddr)
			des_pkg::ADDR_CIPHER_KEY: prdata = key_q;
			default:                  prdata = '0;
		endcase
	end

	des_keysched u_ks (
		.clk(clk), .arst_n(arst_n), .key_wr(key_wr), .key(pwdata),
		.rkeys(rkeys), .key_loaded(key_loaded)
	);

	// Register the item after the initial permutation
	assign t_ip = des_pkg::perm_ip(block_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_s1.valid <= 1'b0;
		end else begin
			in_s1.valid <= start && !busy;
			in_s1.kind  <= kind;
			in_s1.ok    <= key_loaded;
			in_s1.l     <= t_ip[63:32];
			in_s1.r     <= t_ip[31:0];
		end
	end

	assign pipe[0] = in_s1;

	// Sixteen round stages
	for (genvar g = 0; g < NR; g++) begin : g_round
		des_round u_rnd (
			.clk(clk), .arst_n(arst_n), .in_s(pipe[g]),
			.k_enc(rkeys[g]), .k_dec(rkeys[NR-1-g]), .out_s(pipe[g+1])
		);
	end

	// Final permutation into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= pipe[NR].valid;
	end

	always_ff @(posedge clk) begin
		ok_q  <= pipe[NR].ok;
		out_q <= pipe[NR].ok ? des_pkg::perm_fp({pipe[NR].r, pipe[NR].l}) : '0;
	end

	assign done      = done_q;
	assign ok        = ok_q;
	assign block_out = out_q;

endmodule

[tb/tb_des_block_cipher.sv]
// Testbench for des_block_cipher: random ECB traffic checked against a DES predictor.
module tb_des_block_cipher;

	localparam logic       KIND_ENC    = 1'b0;
	localparam logic       KIND_DEC    = 1'b1;
	localparam int         LATENCY     = 18;
	localparam int         STALL_LIMIT = 5000;

	typedef struct {
		des_pkg::block_t blk;
		logic            ok;
	} cipher_result_t;

	// Expected-block store with its own copy of the key schedule.
	class des_scoreboard;
		des_pkg::rkey_t subkeys [16];
		logic           key_loaded;
		cipher_result_t pending_q [$];
		int unsigned    errors;

		function new();
			key_loaded = 1'b0;
			errors     = 0;
		endfunction

		// Track key register writes; other addresses are ignored.
		function void write_key(logic [2:0] addr, logic [63:0] data);
			logic [63:0] key;
			logic [55:0] cd;
			logic [27:0] c;
			logic [27:0] d;
			logic [55:0] joined;
			int          s;
			if (addr == des_pkg::ADDR_CIPHER_KEY) begin
				key = data;
				for (int i = 0; i < 56; i++) cd[55-i] = key[64-des_pkg::TAB_PC1[i]];
				c = cd[55:28];
				d = cd[27:0];
				for (int n = 0; n < 16; n++) begin
					s = des_pkg::TAB_SHIFT[n];
					c = (c << s) | (c >> (28 - s));
					d = (d << s) | (d >> (28 - s));
					joined = {c, d};
					for (int i = 0; i < 48; i++)
						subkeys[n][47-i] = joined[56-des_pkg::TAB_PC2[i]];
				end
				key_loaded = 1'b1;
			end
		endfunction

		function logic [31:0] mix(logic [31:0] half, des_pkg::rkey_t k);
			logic [47:0] x;
			logic [31:0] sb;
			logic [31:0] res;
			int          b;
			int          row;
			int          col;
			for (int i = 0; i < 48; i++) x[47-i] = half[32-des_pkg::TAB_E[i]];
			x = x ^ k;
			for (int i = 0; i < 8; i++) begin
				b   = x[47-6*i -: 6];
				row = ((b >> 4) & 2) | (b & 1);
				col = (b >> 1) & 15;
				sb[31-4*i -: 4] = des_pkg::TAB_S[i][row*16 + col];
			end
			for (int i = 0; i < 32; i++) res[31-i] = sb[32-des_pkg::TAB_P[i]];
			return res;
		endfunction

		// Compute the result of an accepted item and queue it.
		function void note_item(logic kind, des_pkg::block_t blk);
			cipher_result_t exp_res;
			logic [63:0]    t;
			logic [31:0]    l;
			logic [31:0]    r;
			logic [31:0]    nr;
			if (!key_loaded) begin
				exp_res.blk = '0;
				exp_res.ok  = 1'b0;
			end else begin
				for (int i = 0; i < 64; i++) t[63-i] = blk[64-des_pkg::TAB_IP[i]];
				l = t[63:32];
				r = t[31:0];
				for (int n = 0; n < 16; n++) begin
					nr = l ^ mix(r, subkeys[(kind == KIND_DEC) ? 15 - n : n]);
					l  = r;
					r  = nr;
				end
				t = {r, l};
				for (int i = 0; i < 64; i++) exp_res.blk[63-i] = t[64-des_pkg::TAB_FP[i]];
				exp_res.ok = 1'b1;
			end
			pending_q.push_back(exp_res);
		endfunction

		// Compare a delivered block with the oldest expectation.
		function void check_result(des_pkg::block_t blk, logic ok);
			cipher_result_t exp_res;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result block_out=%h ok=%b", $time, blk, ok);
				errors++;
				return;
			end
			exp_res = pending_q.pop_front();
			if (blk !== exp_res.blk) begin
				$display("%0t: block_out mismatch expected %h actual %h",
					$time, exp_res.blk, blk);
				errors++;
			end
			if (ok !== exp_res.ok) begin
				$display("%0t: ok mismatch expected %b actual %b", $time, exp_res.ok, ok);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;
	logic        start;
	logic        busy;
	logic        kind;
	logic [63:0] block_in;
	logic        done;
	logic [63:0] block_out;
	logic        ok;

	des_scoreboard sb;
	int unsigned   idle_cycles;
	logic          dense;

	des_block_cipher u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.start    (start),
		.busy     (busy),
		.kind     (kind),
		.block_in (block_in),
		.done     (done),
		.block_out(block_out),
		.ok       (ok)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Observe key writes, accepted items and results at each edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (psel && penable && pwrite && pready) sb.write_key(paddr, pwdata);
			if (start && !busy) sb.note_item(kind, block_in);
			if (done) sb.check_result(block_out, ok);
		end
	end

	// Stop the run if nothing moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("tb_des_block_cipher failed");
				$finish;
			end
		end
	end

	task automatic idle_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (dense || pick < 60) return;
		start <= 1'b0;
		if (pick < 95) repeat ($urandom_range(1, 3)) @(posedge clk);
		else repeat ($urandom_range(10, 40)) @(posedge clk);
	endtask

	task automatic send_block(logic k, des_pkg::block_t blk);
		start    <= 1'b1;
		kind     <= k;
		block_in <= blk;
		@(posedge clk);
		while (busy) @(posedge clk);
		idle_gap();
	endtask

	// Drain the pipeline, then write the key in one APB write.
	task automatic load_key(logic [63:0] key);
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= des_pkg::ADDR_CIPHER_KEY;
		pwdata  <= key;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	function automatic des_pkg::block_t rand_block();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 85) return {$urandom(), $urandom()};
		if (pick < 90) return '0;
		if (pick < 95) return '1;
		return 64'd1 << $urandom_range(0, 63);
	endfunction

	initial begin
		des_pkg::block_t ct;
		sb       = new();
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		start    = 1'b0;
		kind     = KIND_ENC;
		block_in = '0;
		dense    = 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// No key yet: results are zero with ok low.
		send_block(KIND_ENC, 64'h0123_4567_89AB_CDEF);
		send_block(KIND_DEC, '1);
		send_block(KIND_ENC, '0);

		// Standard example key and block, then its decryption.
		load_key(64'h1334_5779_9BBC_DFF1);
		send_block(KIND_ENC, 64'h0123_4567_89AB_CDEF);
		send_block(KIND_DEC, 64'h85E8_1354_0F0A_B405);
		send_block(KIND_ENC, '0);
		send_block(KIND_ENC, '1);
		send_block(KIND_DEC, '0);
		send_block(KIND_DEC, '1);

		// Extreme keys.
		load_key('0);
		send_block(KIND_ENC, '0);
		send_block(KIND_DEC, '1);
		send_block(KIND_ENC, 64'h8000_0000_0000_0001);
		load_key('1);
		send_block(KIND_ENC, '1);
		send_block(KIND_DEC, '0);
		send_block(KIND_DEC, 64'h8000_0000_0000_0001);

		// Random phases, each under a fresh key.
		for (int phase = 0; phase < 5; phase++) begin
			load_key((phase == 4) ? 64'hFEFE_FEFE_FEFE_FEFE : {$urandom(), $urandom()});
			for (int i = 0; i < 250; i++) begin
				if (i % 50 == 0) dense = ($urandom_range(0, 3) == 0);
				ct = rand_block();
				send_block(1'($urandom_range(0, 1)), ct);
			end
		end
		dense = 1'b1;
		start <= 1'b0;

		// Wait for the pipeline to empty.
		@(posedge clk);
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
		if (sb.errors == 0 && sb.pending_q.size() == 0) begin
			$display("tb_des_block_cipher passed");
		end else begin
			$display("tb_des_block_cipher failed");
		end
		$finish;
	end
endmodule
